>>> rtl/chse_pkg.sv
// Package for the cubic Hermite spline engine: sizes, codes, beat types and
// the rounding helper used by the top level.
// No dependencies.
package chse_pkg;

    localparam int MAX_POINTS    = 64;
    localparam int FRAC_BITS     = 16;
    localparam int COORD_WIDTH   = 32;
    localparam int TENSION_WIDTH = 19;
    localparam int INDEX_WIDTH   = 6;
    localparam int COUNT_WIDTH   = 7;
    localparam int PARAM_WIDTH   = 22;
    localparam int ADDR_WIDTH    = $clog2(MAX_POINTS);
    localparam int H_WIDTH       = FRAC_BITS + 4;
    localparam int F_WIDTH       = TENSION_WIDTH + 1;
    localparam int PROD_WIDTH    = H_WIDTH + COORD_WIDTH;
    localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
    localparam int CV_WIDTH      = DIFF_WIDTH + F_WIDTH;
    localparam int ACC_WIDTH     = PROD_WIDTH + 4;

    localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = COUNT_WIDTH'(MAX_POINTS);

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;
    localparam logic [2:0] OP_CARD   = 3'd6;
    localparam logic [2:0] OP_EVAL   = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_FEW   = 2'd3;

    typedef struct packed {
        logic [2:0]                    opcode;
        logic [INDEX_WIDTH-1:0]        point_index;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] vel_x;
        logic signed [COORD_WIDTH-1:0] vel_y;
        logic signed [COORD_WIDTH-1:0] end_vel_x;
        logic signed [COORD_WIDTH-1:0] end_vel_y;
        logic                          normalized;
        logic [PARAM_WIDTH-1:0]        param_t;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_vel_x;
        logic signed [COORD_WIDTH-1:0] out_vel_y;
        logic [COUNT_WIDTH-1:0]        point_count;
        logic [1:0]                    status;
    } t_result;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_point;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_WIDTH-1:0] rd_addr;
        logic                  pos_we;
        logic                  vel_we;
        logic [ADDR_WIDTH-1:0] wr_addr;
        t_point                pos_wdata;
        t_point                vel_wdata;
    } t_mem_req;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SH_RD, S_SH_WR, S_PUT, S_RM_RD, S_RM_WR, S_RD_OUT,
        S_CV_END0, S_CV_END1, S_CV_RA, S_CV_RB, S_CV_DX, S_CV_MX, S_CV_MY,
        S_CV_WR, S_EV_S, S_EV_CHK, S_EV_RD1, S_EV_RD2, S_EV_H, S_EV_MAC,
        S_EV_FIN, S_DONE
    } t_state;

    localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
        ACC_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

    // round to nearest (halves upward), then clamp to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] round_sat(
        input logic signed [ACC_WIDTH-1:0] v,
        input int unsigned                 sh
    );
        logic signed [ACC_WIDTH-1:0] r;
        logic signed [ACC_WIDTH-1:0] half;
        half = $signed(ACC_WIDTH'(1) << (sh - 1));
        r = v + half;
        r = r >>> sh;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[COORD_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/chse_store.sv
// Point store: position and velocity memories, one write and one registered
// read per cycle each. Depends on chse_pkg.
module chse_store (
    input  logic              i_clk,
    input  chse_pkg::t_mem_req i_req,
    output chse_pkg::t_point  o_pos_q,
    output chse_pkg::t_point  o_vel_q
);

    chse_pkg::t_point pos_mem [chse_pkg::MAX_POINTS];
    chse_pkg::t_point vel_mem [chse_pkg::MAX_POINTS];
    chse_pkg::t_point r_pos_q;
    chse_pkg::t_point r_vel_q;

    always_ff @(posedge i_clk) begin
        if (i_req.pos_we) begin
            pos_mem[i_req.wr_addr] <= i_req.pos_wdata;
        end
        if (i_req.vel_we) begin
            vel_mem[i_req.wr_addr] <= i_req.vel_wdata;
        end
        if (i_req.rd_en) begin
            r_pos_q <= pos_mem[i_req.rd_addr];
            r_vel_q <= vel_mem[i_req.rd_addr];
        end
    end

    assign o_pos_q = r_pos_q;
    assign o_vel_q = r_vel_q;

endmodule

>>> rtl/cubic_hermite_spline_engine_unit.sv
// Cubic Hermite spline engine: point table operations and evaluation.
// It handles clear and error beats, set, read, evaluate (with an end point case),
// the cardinal velocity pass, and insert and remove with their entry shifts; one item
// at a time. busy drops with the result strobe, so the next beat can be taken at the
// edge that takes the result.
// Reset (synchronous, active low) empties the table and clears tension.
module cubic_hermite_spline_engine_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  chse_pkg::t_cmd                        i_cmd,
    output logic                                  busy,
    output logic                                  o_done,
    output chse_pkg::t_result                     o_result,
    input  logic                                  i_cfg_we,
    input  logic signed [chse_pkg::TENSION_WIDTH-1:0] i_cfg_wdata
);

    localparam int CW = chse_pkg::COUNT_WIDTH;
    localparam int AW = chse_pkg::ADDR_WIDTH;
    localparam int FB = chse_pkg::FRAC_BITS;
    localparam int HW = chse_pkg::H_WIDTH;
    localparam int PW = chse_pkg::PARAM_WIDTH;

    chse_pkg::t_state r_state, n_state;
    logic             r_done, n_done;
    logic [CW-1:0]    r_count, n_count;
    logic signed [chse_pkg::TENSION_WIDTH-1:0] r_tension;

    chse_pkg::t_cmd   r_cmd;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [1:0]       r_status, n_status;
    logic signed [chse_pkg::COORD_WIDTH-1:0] r_ox, r_oy, r_ovx, r_ovy;
    logic signed [chse_pkg::COORD_WIDTH-1:0] n_ox, n_oy, n_ovx, n_ovy;

    logic [PW-1:0]    r_s;
    logic             r_end;
    logic [FB-1:0]    r_u, r_u2, r_u3;
    chse_pkg::t_point r_p0, r_v0, r_p1, r_v1, r_pa;
    logic signed [HW-1:0] r_h [4];
    logic [3:0]       r_step;
    logic signed [chse_pkg::PROD_WIDTH-1:0] r_prod;
    logic signed [chse_pkg::ACC_WIDTH-1:0]  r_acc_x, r_acc_y;
    logic signed [chse_pkg::DIFF_WIDTH-1:0] r_dx, r_dy;
    logic signed [chse_pkg::CV_WIDTH-1:0]   r_mx, r_my;

    chse_pkg::t_mem_req w_req;
    chse_pkg::t_point   w_pos_q, w_vel_q;

    logic [CW-1:0]  w_idx, w_ins_idx;
    logic           w_bad_ins, w_full, w_bad_idx, w_few, w_sh_more, w_rm_more, w_ev_end;
    logic [AW-1:0]  w_segs, w_k;
    logic [2*FB-1:0] w_uu, w_u2u;
    logic signed [HW-1:0] w_eu, w_eu2, w_eu3, w_hsel;
    logic signed [chse_pkg::COORD_WIDTH-1:0] w_psel;
    logic signed [chse_pkg::F_WIDTH-1:0] w_f;
    chse_pkg::t_point w_sel_pt;

    chse_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_pos_q (w_pos_q),
        .o_vel_q (w_vel_q)
    );

    assign w_idx     = CW'(r_cmd.point_index);
    assign w_ins_idx = (r_cmd.opcode == chse_pkg::OP_APPEND) ? r_count : w_idx;
    assign w_bad_ins = w_ins_idx > r_count;
    assign w_full    = r_count >= chse_pkg::MAX_COUNT;
    assign w_bad_idx = w_idx >= r_count;
    assign w_few     = r_count < CW'(2);
    assign w_sh_more = CW'(r_ptr - CW'(1)) > w_ins_idx;
    assign w_rm_more = CW'(r_ptr + CW'(2)) < r_count;
    assign w_segs    = AW'(r_count - CW'(1));
    assign w_ev_end  = r_end || (r_s >= (PW'(w_segs) << FB));
    assign w_k       = r_s[FB +: AW];
    assign w_uu      = r_u * r_u;
    assign w_u2u     = r_u2 * r_u;
    assign w_eu      = $signed(HW'(r_u));
    assign w_eu2     = $signed(HW'(r_u2));
    assign w_eu3     = $signed(HW'(r_u3));
    assign w_f       = $signed(chse_pkg::F_WIDTH'(1 << FB)) - chse_pkg::F_WIDTH'(r_tension);

    // multiply-accumulate term order: p0, v0, p1, v1 for x, then for y
    always_comb begin
        case (r_step[1:0])
            2'd0:    w_sel_pt = r_p0;
            2'd1:    w_sel_pt = r_v0;
            2'd2:    w_sel_pt = r_p1;
            default: w_sel_pt = r_v1;
        endcase
        w_psel = r_step[2] ? w_sel_pt.y : w_sel_pt.x;
        w_hsel = r_h[r_step[1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chse_pkg::S_IDLE:   if (start) n_state = chse_pkg::S_DECODE;
            chse_pkg::S_DECODE: begin
                unique case (r_cmd.opcode)
                    chse_pkg::OP_APPEND, chse_pkg::OP_INSERT: begin
                        if (w_bad_ins || w_full) n_state = chse_pkg::S_DONE;
                        else if (r_count > w_ins_idx) n_state = chse_pkg::S_SH_RD;
                        else n_state = chse_pkg::S_PUT;
                    end
                    chse_pkg::OP_REMOVE: begin
                        if (!w_bad_idx && (CW'(w_idx + CW'(1)) < r_count))
                            n_state = chse_pkg::S_RM_RD;
                        else n_state = chse_pkg::S_DONE;
                    end
                    chse_pkg::OP_CLEAR: n_state = chse_pkg::S_DONE;
                    chse_pkg::OP_SET:
                        n_state = w_bad_idx ? chse_pkg::S_DONE : chse_pkg::S_PUT;
                    chse_pkg::OP_READ:
                        n_state = w_bad_idx ? chse_pkg::S_DONE : chse_pkg::S_RD_OUT;
                    chse_pkg::OP_CARD:
                        n_state = w_few ? chse_pkg::S_DONE : chse_pkg::S_CV_END0;
                    default:
                        n_state = w_few ? chse_pkg::S_DONE : chse_pkg::S_EV_S;
                endcase
            end
            chse_pkg::S_SH_RD:  n_state = chse_pkg::S_SH_WR;
            chse_pkg::S_SH_WR:  n_state = w_sh_more ? chse_pkg::S_SH_RD : chse_pkg::S_PUT;
            chse_pkg::S_PUT:    n_state = chse_pkg::S_DONE;
            chse_pkg::S_RM_RD:  n_state = chse_pkg::S_RM_WR;
            chse_pkg::S_RM_WR:  n_state = w_rm_more ? chse_pkg::S_RM_RD : chse_pkg::S_DONE;
            chse_pkg::S_RD_OUT: n_state = chse_pkg::S_DONE;
            chse_pkg::S_CV_END0: n_state = chse_pkg::S_CV_END1;
            chse_pkg::S_CV_END1:
                n_state = (r_count > CW'(2)) ? chse_pkg::S_CV_RA : chse_pkg::S_DONE;
            chse_pkg::S_CV_RA:  n_state = chse_pkg::S_CV_RB;
            chse_pkg::S_CV_RB:  n_state = chse_pkg::S_CV_DX;
            chse_pkg::S_CV_DX:  n_state = chse_pkg::S_CV_MX;
            chse_pkg::S_CV_MX:  n_state = chse_pkg::S_CV_MY;
            chse_pkg::S_CV_MY:  n_state = chse_pkg::S_CV_WR;
            chse_pkg::S_CV_WR:  n_state = w_rm_more ? chse_pkg::S_CV_RA : chse_pkg::S_DONE;
            chse_pkg::S_EV_S:   n_state = chse_pkg::S_EV_CHK;
            chse_pkg::S_EV_CHK: n_state = w_ev_end ? chse_pkg::S_RD_OUT : chse_pkg::S_EV_RD1;
            chse_pkg::S_EV_RD1: n_state = chse_pkg::S_EV_RD2;
            chse_pkg::S_EV_RD2: n_state = chse_pkg::S_EV_H;
            chse_pkg::S_EV_H:   n_state = chse_pkg::S_EV_MAC;
            chse_pkg::S_EV_MAC: if (r_step == 4'd8) n_state = chse_pkg::S_EV_FIN;
            chse_pkg::S_EV_FIN: n_state = chse_pkg::S_DONE;
            chse_pkg::S_DONE:   n_state = chse_pkg::S_IDLE;
            default:            n_state = chse_pkg::S_IDLE;
        endcase
    end

    // outputs, store requests and datapath updates
    always_comb begin
        n_done   = 1'b0;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_status = r_status;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_ovx    = r_ovx;
        n_ovy    = r_ovy;
        w_req    = '0;
        unique case (r_state)
            chse_pkg::S_DECODE: begin
                n_ox = '0;
                n_oy = '0;
                n_ovx = '0;
                n_ovy = '0;
                n_status = chse_pkg::ST_OK;
                unique case (r_cmd.opcode)
                    chse_pkg::OP_APPEND, chse_pkg::OP_INSERT: begin
                        if (w_bad_ins) n_status = chse_pkg::ST_INDEX;
                        else if (w_full) n_status = chse_pkg::ST_FULL;
                        n_ptr = r_count;
                    end
                    chse_pkg::OP_REMOVE, chse_pkg::OP_SET: begin
                        if (w_bad_idx) n_status = chse_pkg::ST_INDEX;
                        n_ptr = w_idx;
                    end
                    chse_pkg::OP_READ: begin
                        if (w_bad_idx) n_status = chse_pkg::ST_INDEX;
                        w_req.rd_en = !w_bad_idx;
                        w_req.rd_addr = w_idx[AW-1:0];
                    end
                    chse_pkg::OP_CARD, chse_pkg::OP_EVAL: begin
                        if (w_few) n_status = chse_pkg::ST_FEW;
                        n_ptr = CW'(1);
                    end
                    default: ;
                endcase
            end
            chse_pkg::S_SH_RD: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = AW'(r_ptr - CW'(1));
            end
            chse_pkg::S_SH_WR: begin
                w_req.pos_we = 1'b1;
                w_req.vel_we = 1'b1;
                w_req.wr_addr = r_ptr[AW-1:0];
                w_req.pos_wdata = w_pos_q;
                w_req.vel_wdata = w_vel_q;
                n_ptr = CW'(r_ptr - CW'(1));
            end
            chse_pkg::S_PUT: begin
                w_req.pos_we = 1'b1;
                w_req.vel_we = 1'b1;
                w_req.wr_addr = w_ins_idx[AW-1:0];
                w_req.pos_wdata = '{x: r_cmd.pos_x, y: r_cmd.pos_y};
                w_req.vel_wdata = '{x: r_cmd.vel_x, y: r_cmd.vel_y};
            end
            chse_pkg::S_RM_RD: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = AW'(r_ptr + CW'(1));
            end
            chse_pkg::S_RM_WR: begin
                w_req.pos_we = 1'b1;
                w_req.vel_we = 1'b1;
                w_req.wr_addr = r_ptr[AW-1:0];
                w_req.pos_wdata = w_pos_q;
                w_req.vel_wdata = w_vel_q;
                n_ptr = CW'(r_ptr + CW'(1));
            end
            chse_pkg::S_RD_OUT: begin
                n_ox = w_pos_q.x;
                n_oy = w_pos_q.y;
                if (r_cmd.opcode == chse_pkg::OP_READ) begin
                    n_ovx = w_vel_q.x;
                    n_ovy = w_vel_q.y;
                end
            end
            chse_pkg::S_CV_END0: begin
                w_req.vel_we = 1'b1;
                w_req.wr_addr = '0;
                w_req.vel_wdata = '{x: r_cmd.vel_x, y: r_cmd.vel_y};
            end
            chse_pkg::S_CV_END1: begin
                w_req.vel_we = 1'b1;
                w_req.wr_addr = w_segs;
                w_req.vel_wdata = '{x: r_cmd.end_vel_x, y: r_cmd.end_vel_y};
            end
            chse_pkg::S_CV_RA: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = AW'(r_ptr - CW'(1));
            end
            chse_pkg::S_CV_RB: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = AW'(r_ptr + CW'(1));
            end
            chse_pkg::S_CV_WR: begin
                w_req.vel_we = 1'b1;
                w_req.wr_addr = r_ptr[AW-1:0];
                w_req.vel_wdata.x = chse_pkg::round_sat(chse_pkg::ACC_WIDTH'(r_mx), FB + 1);
                w_req.vel_wdata.y = chse_pkg::round_sat(chse_pkg::ACC_WIDTH'(r_my), FB + 1);
                n_ptr = CW'(r_ptr + CW'(1));
            end
            chse_pkg::S_EV_CHK: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = w_ev_end ? w_segs : w_k;
            end
            chse_pkg::S_EV_RD1: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = AW'(w_k + AW'(1));
            end
            chse_pkg::S_EV_FIN: begin
                n_ox = chse_pkg::round_sat(r_acc_x, FB);
                n_oy = chse_pkg::round_sat(r_acc_y, FB);
            end
            chse_pkg::S_DONE: begin
                n_done = 1'b1;
                if (r_status == chse_pkg::ST_OK) begin
                    case (r_cmd.opcode)
                        chse_pkg::OP_APPEND, chse_pkg::OP_INSERT:
                            n_count = CW'(r_count + CW'(1));
                        chse_pkg::OP_REMOVE: n_count = CW'(r_count - CW'(1));
                        chse_pkg::OP_CLEAR:  n_count = '0;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= chse_pkg::S_IDLE;
            r_done    <= 1'b0;
            r_count   <= '0;
            r_tension <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_tension <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ovx    <= n_ovx;
        r_ovy    <= n_ovy;
        if (r_state == chse_pkg::S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        unique case (r_state)
            chse_pkg::S_CV_RB: r_pa <= w_pos_q;
            chse_pkg::S_CV_DX: begin
                r_dx <= chse_pkg::DIFF_WIDTH'(w_pos_q.x) - chse_pkg::DIFF_WIDTH'(r_pa.x);
                r_dy <= chse_pkg::DIFF_WIDTH'(w_pos_q.y) - chse_pkg::DIFF_WIDTH'(r_pa.y);
            end
            chse_pkg::S_CV_MX: r_mx <= r_dx * w_f;
            chse_pkg::S_CV_MY: r_my <= r_dy * w_f;
            chse_pkg::S_EV_S: begin
                // normalised: scale by segment count; at or past one means the end
                r_end <= r_cmd.normalized && (r_cmd.param_t >= PW'(1 << FB));
                if (r_cmd.normalized) begin
                    r_s <= PW'(r_cmd.param_t[FB-1:0]) * PW'(w_segs);
                end else begin
                    r_s <= r_cmd.param_t;
                end
            end
            chse_pkg::S_EV_CHK: r_u <= r_s[FB-1:0];
            chse_pkg::S_EV_RD1: begin
                r_p0 <= w_pos_q;
                r_v0 <= w_vel_q;
                r_u2 <= w_uu[2*FB-1:FB];
            end
            chse_pkg::S_EV_RD2: begin
                r_p1 <= w_pos_q;
                r_v1 <= w_vel_q;
                r_u3 <= w_u2u[2*FB-1:FB];
            end
            chse_pkg::S_EV_H: begin
                r_h[0]  <= (w_eu3 <<< 1) - (w_eu2 + (w_eu2 <<< 1)) + HW'(1 << FB);
                r_h[1]  <= w_eu3 - (w_eu2 <<< 1) + w_eu;
                r_h[2]  <= (w_eu2 + (w_eu2 <<< 1)) - (w_eu3 <<< 1);
                r_h[3]  <= w_eu3 - w_eu2;
                r_step  <= '0;
                r_acc_x <= '0;
                r_acc_y <= '0;
            end
            chse_pkg::S_EV_MAC: begin
                // product of this step, sum of the one before
                if (!r_step[3]) begin
                    r_prod <= w_hsel * w_psel;
                end
                if (r_step != 4'd0) begin
                    if (r_step <= 4'd4) r_acc_x <= r_acc_x + chse_pkg::ACC_WIDTH'(r_prod);
                    else r_acc_y <= r_acc_y + chse_pkg::ACC_WIDTH'(r_prod);
                end
                r_step <= r_step + 4'd1;
            end
            default: ;
        endcase
    end

    assign busy   = (r_state != chse_pkg::S_IDLE);
    assign o_done = r_done;

    always_comb begin
        o_result.out_x       = r_ox;
        o_result.out_y       = r_oy;
        o_result.out_vel_x   = r_ovx;
        o_result.out_vel_y   = r_ovy;
        o_result.point_count = r_count;
        o_result.status      = r_status;
    end

`ifndef SYNTH
    a_done_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == chse_pkg::S_DONE)
        else $error("result beat without a finished operation");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat held for more than one cycle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= chse_pkg::MAX_COUNT)
        else $error("point count beyond table depth");
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == chse_pkg::ST_FULL) |->
        o_result.point_count == chse_pkg::MAX_COUNT)
        else $error("table full reported below capacity");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for the cubic Hermite spline engine: a directed table of commands,
// then random phases under several tension settings, checked against a local
// point-table predictor or fixed results. Depends on chse_pkg and the engine.
module tb;
    import chse_pkg::*;

    localparam int N_DIRECTED = 23;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;
    logic    i_cfg_we = 1'b0;
    logic signed [TENSION_WIDTH-1:0] i_cfg_wdata = '0;

    cubic_hermite_spline_engine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [COORD_WIDTH-1:0] tab_px[MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] tab_py[MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] tab_vx[MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] tab_vy[MAX_POINTS];
    int          held = 0;
    longint      cur_tension = 0;

    // directed stimulus table
    t_cmd    dir_cmd[N_DIRECTED];
    bit      dir_typed[N_DIRECTED];
    t_result dir_res[N_DIRECTED];
    int      n_rows = 0;

    t_result pending_results[$];
    int      fails = 0;
    int      n_cmds = 0;
    int      n_checked = 0;
    int      n_settings = 0;
    bit      beat_taken = 1'b0;
    int      burst_left = 0;

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic longint round_down_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] hermite_at(
        longint p0, longint v0, longint p1, longint v1, longint u);
        longint u2, u3, h00, h10, h01, h11, acc;
        u2  = (u * u) >>> FRAC_BITS;
        u3  = (u2 * u) >>> FRAC_BITS;
        h00 = 2 * u3 - 3 * u2 + (64'sd1 <<< FRAC_BITS);
        h10 = u3 - 2 * u2 + u;
        h01 = 3 * u2 - 2 * u3;
        h11 = u3 - u2;
        acc = h00 * p0 + h10 * v0 + h01 * p1 + h11 * v1;
        return clamp_coord(round_down_shift(acc, FRAC_BITS));
    endfunction

    // apply one command to the local table and return the result it gives
    function automatic t_result spline_predict(t_cmd c);
        t_result r;
        int      idx, n;
        longint  f, segs, s, dx, dy;
        r   = '0;
        n   = held;
        idx = c.point_index;
        case (c.opcode)
            OP_APPEND, OP_INSERT: begin
                if (c.opcode == OP_APPEND) idx = n;
                if (idx > n) begin
                    r.status = ST_INDEX;
                end else if (n >= MAX_POINTS) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = n; i > idx; i--) begin
                        tab_px[i] = tab_px[i-1]; tab_py[i] = tab_py[i-1];
                        tab_vx[i] = tab_vx[i-1]; tab_vy[i] = tab_vy[i-1];
                    end
                    tab_px[idx] = c.pos_x; tab_py[idx] = c.pos_y;
                    tab_vx[idx] = c.vel_x; tab_vy[idx] = c.vel_y;
                    held = n + 1;
                end
            end
            OP_REMOVE: begin
                if (idx >= n) begin
                    r.status = ST_INDEX;
                end else begin
                    for (int i = idx; i + 1 < n; i++) begin
                        tab_px[i] = tab_px[i+1]; tab_py[i] = tab_py[i+1];
                        tab_vx[i] = tab_vx[i+1]; tab_vy[i] = tab_vy[i+1];
                    end
                    held = n - 1;
                end
            end
            OP_CLEAR: held = 0;
            OP_SET: begin
                if (idx >= n) begin
                    r.status = ST_INDEX;
                end else begin
                    tab_px[idx] = c.pos_x; tab_py[idx] = c.pos_y;
                    tab_vx[idx] = c.vel_x; tab_vy[idx] = c.vel_y;
                end
            end
            OP_READ: begin
                if (idx >= n) begin
                    r.status = ST_INDEX;
                end else begin
                    r.out_x = tab_px[idx]; r.out_y = tab_py[idx];
                    r.out_vel_x = tab_vx[idx]; r.out_vel_y = tab_vy[idx];
                end
            end
            OP_CARD: begin
                f = (64'sd1 <<< FRAC_BITS) - cur_tension;
                if (n < 2) begin
                    r.status = ST_FEW;
                end else begin
                    tab_vx[0] = c.vel_x; tab_vy[0] = c.vel_y;
                    tab_vx[n-1] = c.end_vel_x; tab_vy[n-1] = c.end_vel_y;
                    for (int i = 1; i + 1 < n; i++) begin
                        dx = longint'(tab_px[i+1]) - longint'(tab_px[i-1]);
                        dy = longint'(tab_py[i+1]) - longint'(tab_py[i-1]);
                        tab_vx[i] = clamp_coord(round_down_shift(dx * f, FRAC_BITS + 1));
                        tab_vy[i] = clamp_coord(round_down_shift(dy * f, FRAC_BITS + 1));
                    end
                end
            end
            default: begin
                if (n < 2) begin
                    r.status = ST_FEW;
                end else begin
                    segs = n - 1;
                    if (c.normalized) begin
                        s = (c.param_t >= (1 << FRAC_BITS)) ? (segs <<< FRAC_BITS)
                                                            : longint'(c.param_t) * segs;
                    end else begin
                        s = c.param_t;
                    end
                    if (s >= (segs <<< FRAC_BITS)) begin
                        r.out_x = tab_px[n-1]; r.out_y = tab_py[n-1];
                    end else begin
                        idx = int'(s >>> FRAC_BITS);
                        s   = s & ((64'sd1 <<< FRAC_BITS) - 1);
                        r.out_x = hermite_at(tab_px[idx], tab_vx[idx], tab_px[idx+1],
                                             tab_vx[idx+1], s);
                        r.out_y = hermite_at(tab_py[idx], tab_vy[idx], tab_py[idx+1],
                                             tab_vy[idx+1], s);
                    end
                end
            end
        endcase
        r.point_count = COUNT_WIDTH'(held);
        return r;
    endfunction

    // sample at the falling edge, clear of the block's own updates
    always @(negedge i_clk) begin
        t_result want;
        beat_taken <= start && !busy && i_rst_n;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                fails++;
                $display("%0t: result with nothing expected: %p", $time, o_result);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (want !== o_result) begin
                    fails++;
                    if (want.out_x !== o_result.out_x)
                        $display("%0t: out_x exp %h got %h", $time,
                                 want.out_x, o_result.out_x);
                    if (want.out_y !== o_result.out_y)
                        $display("%0t: out_y exp %h got %h", $time,
                                 want.out_y, o_result.out_y);
                    if (want.out_vel_x !== o_result.out_vel_x)
                        $display("%0t: out_vel_x exp %h got %h", $time,
                                 want.out_vel_x, o_result.out_vel_x);
                    if (want.out_vel_y !== o_result.out_vel_y)
                        $display("%0t: out_vel_y exp %h got %h", $time,
                                 want.out_vel_y, o_result.out_vel_y);
                    if (want.point_count !== o_result.point_count)
                        $display("%0t: point_count exp %0d got %0d", $time,
                                 want.point_count, o_result.point_count);
                    if (want.status !== o_result.status)
                        $display("%0t: status exp %0d got %0d", $time,
                                 want.status, o_result.status);
                end
            end
        end
    end

    // hand one beat over, hold it until taken, then maybe open a gap
    task automatic send_cmd(t_cmd c, bit typed, t_result typed_res);
        t_result pred;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (!beat_taken);
        pred = spline_predict(c);
        pending_results.insert(pending_results.size(), typed ? typed_res : pred);
        n_cmds++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_set_tension(logic signed [TENSION_WIDTH-1:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_tension = v;
        n_settings++;
    endtask

    function automatic t_cmd make_cmd(logic [2:0] op, int idx, longint px, longint py,
                                      longint vx, longint vy, longint ex, longint ey,
                                      bit norm, int t);
        t_cmd c;
        c.opcode = op; c.point_index = idx[INDEX_WIDTH-1:0];
        c.pos_x = px[31:0]; c.pos_y = py[31:0];
        c.vel_x = vx[31:0]; c.vel_y = vy[31:0];
        c.end_vel_x = ex[31:0]; c.end_vel_y = ey[31:0];
        c.normalized = norm; c.param_t = t[PARAM_WIDTH-1:0];
        return c;
    endfunction

    // add one row to the directed table
    function automatic void add_row(t_cmd c, bit typed, t_result res);
        dir_cmd[n_rows]   = c;
        dir_typed[n_rows] = typed;
        dir_res[n_rows]   = res;
        n_rows++;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 5) != 0) v = v >>> $urandom_range(4, 14);
        return v;
    endfunction

    function automatic t_cmd rand_cmd(bit append_only);
        t_cmd c;
        int   w;
        c = t_cmd'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.pos_x = rand_coord(); c.pos_y = rand_coord();
        c.vel_x = rand_coord(); c.vel_y = rand_coord();
        w = $urandom_range(0, 99);
        if (append_only)  c.opcode = OP_APPEND;
        else if (w < 20)  c.opcode = OP_APPEND;
        else if (w < 31)  c.opcode = OP_INSERT;
        else if (w < 43)  c.opcode = OP_REMOVE;
        else if (w < 45)  c.opcode = OP_CLEAR;
        else if (w < 55)  c.opcode = OP_SET;
        else if (w < 67)  c.opcode = OP_READ;
        else if (w < 76)  c.opcode = OP_CARD;
        else              c.opcode = OP_EVAL;
        if ($urandom_range(0, 7) != 0)
            c.point_index = INDEX_WIDTH'($urandom_range(0, (held > 63) ? 63 : held));
        if ($urandom_range(0, 5) != 0) begin
            if (c.normalized) c.param_t = PARAM_WIDTH'($urandom_range(0, 65600));
            else c.param_t = PARAM_WIDTH'($urandom_range(0, held * 65536 + 100));
        end
        return c;
    endfunction

    initial begin
        t_result r0;
        t_result res_few;
        t_result res_index;
        t_result res_index4;
        logic signed [TENSION_WIDTH-1:0] phase_tension[5];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        r0 = '0;
        res_few = '0;
        res_few.status = ST_FEW;
        res_index = '0;
        res_index.status = ST_INDEX;
        res_index4 = res_index;
        res_index4.point_count = COUNT_WIDTH'(4);

        // directed table: empty table errors, extremes, each operation
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res_few);
        add_row(make_cmd(OP_CARD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res_few);
        add_row(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res_index);
        add_row(make_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, res_index);
        add_row(make_cmd(OP_INSERT, 1, 5, 5, 5, 5, 0, 0, 0, 0), 1, res_index);
        add_row(make_cmd(OP_APPEND, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                         32'sh7FFFFFFF, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_APPEND, 0, -64'sd2147483648, -64'sd2147483648,
                         -64'sd2147483648, -64'sd2147483648, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_INSERT, 0, 65536, -65536, 0, 0, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_INSERT, 3, 12345, 678, 9, 10, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_SET, 2, 0, 131072, 65536, -65536, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_SET, 63, 1, 1, 1, 1, 0, 0, 0, 0), 1, res_index4);
        add_row(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 32768), 0, r0);
        add_row(make_cmd(OP_CARD, 0, 0, 0, 32'sh7FFFFFFF, -64'sd2147483648,
                         -64'sd2147483648, 32'sh7FFFFFFF, 0, 0), 0, r0);
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 1, 65535), 0, r0);
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 1, 65536), 0, r0);
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 4194303), 0, r0);
        add_row(make_cmd(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 3 * 65536 - 1), 0, r0);
        add_row(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_REMOVE, 3, 0, 0, 0, 0, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, r0);
        add_row(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, r0);

        for (int k = 0; k < n_rows; k++) begin
            send_cmd(dir_cmd[k], dir_typed[k], dir_res[k]);
        end

        phase_tension[0] = -19'sd131072;
        phase_tension[1] = 19'sd131072;
        phase_tension[2] = 19'sd0;
        phase_tension[3] = TENSION_WIDTH'($urandom);
        phase_tension[4] = TENSION_WIDTH'($urandom);
        for (int ph = 0; ph < 5; ph++) begin
            drain_and_set_tension(phase_tension[ph]);
            // one phase fills the table to the brim and beyond
            if (ph == 1) begin
                send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, r0);
                repeat (MAX_POINTS + 4) send_cmd(rand_cmd(1), 0, r0);
                repeat (4) send_cmd(make_cmd(OP_INSERT, $urandom_range(0, 63), 0, 0, 0,
                                             0, 0, 0, 0, 0), 0, r0);
            end
            repeat (230) send_cmd(rand_cmd(0), 0, r0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("ran %0d commands, checked %0d results over %0d tension settings",
                 n_cmds, n_checked, n_settings + 1);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule
